[hw/rtl/lcs_pkg.sv]
// ============================================================================
// lcs_pkg
// Shared types and constants for the longest common substring engine.
// ============================================================================
package lcs_pkg;

   localparam int CMD_W  = 2;
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 7;
   localparam int IDX_W  = 6;

   localparam logic [CMD_W-1:0] CMD_FIRST   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SECOND  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

   // one table cell issued to the row datapath
   typedef struct packed {
      logic             valid;
      logic             first_row;
      logic             col_zero;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } cell_type;

endpackage

[hw/rtl/lcs_strings.sv]
// ============================================================================
// lcs_strings
// The two string memories; one write and one registered read port each.
// ============================================================================
module lcs_strings #(
   parameter int MAX_LEN = 64,
   parameter int AW      = 6
) (
   input  logic                      clock,
   input  logic                      wr_en_a,
   input  logic                      wr_en_b,
   input  logic [AW-1:0]             wr_addr_a,
   input  logic [AW-1:0]             wr_addr_b,
   input  logic [lcs_pkg::BYTE_W-1:0] wr_data,
   input  logic [AW-1:0]             rd_addr_a,
   input  logic [AW-1:0]             rd_addr_b,
   output logic [lcs_pkg::BYTE_W-1:0] rd_data_a,
   output logic [lcs_pkg::BYTE_W-1:0] rd_data_b
);

   logic [lcs_pkg::BYTE_W-1:0] mem_a [MAX_LEN];
   logic [lcs_pkg::BYTE_W-1:0] mem_b [MAX_LEN];
   logic [lcs_pkg::BYTE_W-1:0] rd_a_ff;
   logic [lcs_pkg::BYTE_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en_a) begin
         mem_a[wr_addr_a] <= wr_data;
      end
      rd_a_ff <= mem_a[rd_addr_a];
   end

   always_ff @(posedge clock) begin
      if (wr_en_b) begin
         mem_b[wr_addr_b] <= wr_data;
      end
      rd_b_ff <= mem_b[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

[hw/rtl/lcs_dp.sv]
// ============================================================================
// lcs_dp
// Match-length row memory with read-modify-write per cell and best-run
// tracking. An issued cell is held in p1_ff, then completed and written back.
// ============================================================================
module lcs_dp #(
   parameter int MAX_LEN = 64,
   parameter int AW      = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  lcs_pkg::cell_type          issue,
   input  logic [lcs_pkg::BYTE_W-1:0] a_byte,
   input  logic [lcs_pkg::BYTE_W-1:0] b_byte,
   input  logic                       clear_best,
   output logic [lcs_pkg::LEN_W-1:0]  best_len,
   output logic [lcs_pkg::LEN_W-1:0]  best_end
);

   localparam int LW = lcs_pkg::LEN_W;

   logic [LW-1:0]     row_mem [MAX_LEN];
   logic [LW-1:0]     row_rd_ff;
   lcs_pkg::cell_type p1_ff;
   logic [LW-1:0]     diag_ff;
   logic [LW-1:0]     best_len_ff, best_len_in;
   logic [LW-1:0]     best_end_ff, best_end_in;

   logic [LW-1:0]     old_val;
   logic [LW-1:0]     diag_val;
   logic [LW-1:0]     cur_val;
   logic              hit;

   always_comb begin
      old_val     = p1_ff.first_row ? '0 : row_rd_ff;
      diag_val    = p1_ff.col_zero ? '0 : diag_ff;
      hit         = (a_byte == b_byte);
      cur_val     = hit ? LW'(diag_val + LW'(1)) : '0;
      best_len_in = best_len_ff;
      best_end_in = best_end_ff;
      if (clear_best) begin
         best_len_in = '0;
         best_end_in = '0;
      end else if (p1_ff.valid && hit && (cur_val > best_len_ff)) begin
         best_len_in = cur_val;
         best_end_in = LW'({1'b0, p1_ff.row} + LW'(1));
      end
   end

   always_ff @(posedge clock) begin
      row_rd_ff <= row_mem[issue.col[AW-1:0]];
      if (p1_ff.valid) begin
         row_mem[p1_ff.col[AW-1:0]] <= cur_val;
         diag_ff                    <= old_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff       <= '0;
         best_len_ff <= '0;
         best_end_ff <= '0;
      end else begin
         p1_ff       <= issue;
         best_len_ff <= best_len_in;
         best_end_ff <= best_end_in;
      end
   end

   assign best_len = best_len_ff;
   assign best_end = best_end_ff;

endmodule

[hw/rtl/longest_common_substring.sv]
// ============================================================================
// longest_common_substring
// Loads two byte strings, fills the match-length table row by row through a
// row memory, then returns the longest common substring byte by byte.
// ============================================================================
//  channel | ports                                    | direction
//  req     | req_valid req_ready req_cmd req_symbol   | in
//  rsp     | rsp_valid rsp_ready rsp_out_byte         | out
//          | rsp_match_len rsp_is_last rsp_none_found |
//          | rsp_overflowed                           |
//
//  Compute word: one table cell per cycle through the row memory, plus a
//  row-start state per row to fetch the first-string byte, plus a drain
//  state for the last cell.
//  Each result word: string memory read, load, hand-off.
//  req_ready is high only while no compute or emission is in progress.
//  Reset clears counts, overflow flag and state; string contents survive.
//  A stalled rsp word holds until taken.
// ============================================================================
module longest_common_substring #(
   parameter int MAX_LEN = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [lcs_pkg::CMD_W-1:0]         req_cmd,
   input  logic [lcs_pkg::BYTE_W-1:0]        req_symbol,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [lcs_pkg::BYTE_W-1:0]        rsp_out_byte,
   output logic [lcs_pkg::LEN_W-1:0]         rsp_match_len,
   output logic                              rsp_is_last,
   output logic                              rsp_none_found,
   output logic                              rsp_overflowed
);

   localparam int LW = lcs_pkg::LEN_W;
   localparam int IW = lcs_pkg::IDX_W;
   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam logic [LW-1:0] MAX_CNT = LW'(MAX_LEN);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_ROW   = 6'b000010,
      S_CELL  = 6'b000100,
      S_DRAIN = 6'b001000,
      S_ERD   = 6'b010000,
      S_ELOAD = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic              emit_ff, emit_in;
   logic [LW-1:0]     cnt_a_ff, cnt_a_in;
   logic [LW-1:0]     cnt_b_ff, cnt_b_in;
   logic              drop_ff, drop_in;
   logic [IW-1:0]     row_ff, row_in;
   logic [IW-1:0]     col_ff, col_in;
   logic [LW-1:0]     k_ff, k_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [lcs_pkg::BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic [LW-1:0]              rsp_len_ff, rsp_len_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic                       rsp_none_ff, rsp_none_in;
   logic                       rsp_ovf_ff, rsp_ovf_in;

   logic                       req_fire;
   logic                       wr_en_a, wr_en_b;
   logic [AW-1:0]              rd_addr_a;
   logic [lcs_pkg::BYTE_W-1:0] rd_data_a, rd_data_b;
   lcs_pkg::cell_type          issue;
   logic                       clear_best;
   logic [LW-1:0]              best_len, best_end;
   logic [LW-1:0]              emit_pos;
   logic                       row_last, col_last;

   assign req_ready = (state_ff == S_IDLE) && !emit_ff;
   assign req_fire  = req_valid && req_ready;
   assign emit_pos  = LW'(best_end - best_len + k_ff);
   assign row_last  = (LW'({1'b0, row_ff}) + LW'(1)) == cnt_a_ff;
   assign col_last  = (LW'({1'b0, col_ff}) + LW'(1)) == cnt_b_ff;

   assign wr_en_a = req_fire && (req_cmd == lcs_pkg::CMD_FIRST) && (cnt_a_ff < MAX_CNT);
   assign wr_en_b = req_fire && (req_cmd == lcs_pkg::CMD_SECOND) && (cnt_b_ff < MAX_CNT);
   assign clear_best = req_fire && (req_cmd == lcs_pkg::CMD_COMPUTE);

   always_comb begin
      rd_addr_a = row_ff[AW-1:0];
      if (state_ff == S_ERD || state_ff == S_ELOAD) begin
         rd_addr_a = emit_pos[AW-1:0];
      end
   end

   always_comb begin
      issue           = '0;
      issue.row       = row_ff;
      issue.col       = col_ff;
      issue.first_row = (row_ff == '0);
      issue.col_zero  = (col_ff == '0);
      issue.valid     = (state_ff == S_CELL);
   end

   always_comb begin
      state_in     = state_ff;
      emit_in      = emit_ff;
      cnt_a_in     = cnt_a_ff;
      cnt_b_in     = cnt_b_ff;
      drop_in      = drop_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_none_in  = rsp_none_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      case (state_ff)
         S_IDLE: begin
            if (emit_ff) begin
               if (rsp_ready) begin
                  rsp_valid_in = 1'b0;
                  if (rsp_last_ff) begin
                     emit_in  = 1'b0;
                     cnt_a_in = '0;
                     cnt_b_in = '0;
                     drop_in  = 1'b0;
                  end else begin
                     k_in     = LW'(k_ff + LW'(1));
                     state_in = S_ERD;
                  end
               end
            end else if (req_fire) begin
               case (req_cmd)
                  lcs_pkg::CMD_FIRST: begin
                     if (cnt_a_ff < MAX_CNT) begin
                        cnt_a_in = LW'(cnt_a_ff + LW'(1));
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
                  lcs_pkg::CMD_SECOND: begin
                     if (cnt_b_ff < MAX_CNT) begin
                        cnt_b_in = LW'(cnt_b_ff + LW'(1));
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
                  lcs_pkg::CMD_COMPUTE: begin
                     row_in = '0;
                     col_in = '0;
                     k_in   = '0;
                     emit_in = 1'b1;
                     if (cnt_a_ff == '0 || cnt_b_ff == '0) begin
                        state_in = S_DRAIN;
                     end else begin
                        state_in = S_ROW;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_ROW: begin
            col_in   = '0;
            state_in = S_CELL;
         end
         S_CELL: begin
            if (col_last) begin
               if (row_last) begin
                  state_in = S_DRAIN;
               end else begin
                  row_in   = IW'(row_ff + IW'(1));
                  state_in = S_ROW;
               end
            end else begin
               col_in = IW'(col_ff + IW'(1));
            end
         end
         S_DRAIN: begin
            state_in = S_ERD;
         end
         S_ERD: begin
            state_in = S_ELOAD;
         end
         S_ELOAD: begin
            rsp_valid_in = 1'b1;
            rsp_ovf_in   = drop_ff;
            rsp_len_in   = best_len;
            if (best_len == '0) begin
               rsp_byte_in = '0;
               rsp_last_in = 1'b1;
               rsp_none_in = 1'b1;
            end else begin
               rsp_byte_in = rd_data_a;
               rsp_last_in = (LW'(k_ff + LW'(1)) == best_len);
               rsp_none_in = 1'b0;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         emit_ff      <= 1'b0;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         drop_ff      <= 1'b0;
         row_ff       <= '0;
         col_ff       <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         emit_ff      <= emit_in;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         drop_ff      <= drop_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_last_ff <= rsp_last_in;
      rsp_none_ff <= rsp_none_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   lcs_strings #(
      .MAX_LEN (MAX_LEN),
      .AW      (AW)
   ) u_strings (
      .clock     (clock),
      .wr_en_a   (wr_en_a),
      .wr_en_b   (wr_en_b),
      .wr_addr_a (cnt_a_ff[AW-1:0]),
      .wr_addr_b (cnt_b_ff[AW-1:0]),
      .wr_data   (req_symbol),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (col_ff[AW-1:0]),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   lcs_dp #(
      .MAX_LEN (MAX_LEN),
      .AW      (AW)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .issue      (issue),
      .a_byte     (rd_data_a),
      .b_byte     (rd_data_b),
      .clear_best (clear_best),
      .best_len   (best_len),
      .best_end   (best_end)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_match_len  = rsp_len_ff;
   assign rsp_is_last    = rsp_last_ff;
   assign rsp_none_found = rsp_none_ff;
   assign rsp_overflowed = rsp_ovf_ff;

endmodule

[hw/rtl/lcs_checker.sv]
// ============================================================================
// lcs_checker
// Port-level checks for the longest common substring engine.
// ============================================================================
module lcs_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [lcs_pkg::BYTE_W-1:0]        rsp_out_byte,
   input logic [lcs_pkg::LEN_W-1:0]         rsp_match_len,
   input logic                              rsp_is_last,
   input logic                              rsp_none_found
);

   // empty result is a single terminal word of length zero
   a_none_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_none_found |-> rsp_is_last && (rsp_match_len == '0))
      else $error("none_found word malformed");

   // a real byte always carries a nonzero length
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_none_found |-> (rsp_match_len != '0))
      else $error("substring word with zero length");

   // no new request taken while a result word is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request accepted during emission");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte))
      else $error("stalled rsp word changed");

endmodule

bind longest_common_substring lcs_checker u_lcs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_match_len  (rsp_match_len),
   .rsp_is_last    (rsp_is_last),
   .rsp_none_found (rsp_none_found)
);
